// ===== rtl/fpsc_pkg.sv =====
package fpsc_pkg;

  localparam int TEMP_W  = 19;
  localparam int ERR_W   = 20;
  localparam int DIFF_W  = 21;
  localparam int INTEG_W = 48;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = 64;
  localparam int DIVR_W  = 18;
  localparam int SUM_W   = 56;
  localparam int SPEED_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TEMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd6;

  localparam logic [DIVR_W-1:0]  DIV_1000  = 18'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_INT = 2'd0,
    OP_P   = 2'd1,
    OP_I   = 2'd2,
    OP_D   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  function automatic logic [DIVR_W-1:0] times1000(input logic [7:0] x);
    logic [DIVR_W-1:0] w;
    w = {10'd0, x};
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

endpackage

// ===== rtl/fpsc_mul.sv =====
module fpsc_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [fpsc_pkg::INTEG_W-1:0]    a,
  input  logic signed [fpsc_pkg::GAIN_W-1:0]     b,
  output logic                                   done,
  output logic signed [fpsc_pkg::PROD_W-1:0]     prod
);

  logic                                  busy_r;
  logic                                  done_r;
  logic [$clog2(fpsc_pkg::MUL_STEPS)-1:0] cnt_r;
  logic [fpsc_pkg::PROD_W-1:0]           mcand_r;
  logic [fpsc_pkg::GAIN_W-1:0]           mplier_r;
  logic [fpsc_pkg::PROD_W-1:0]           acc_r;
  logic [fpsc_pkg::PROD_W-1:0]           addend;
  logic                                  last;

  assign addend = mplier_r[0] ? mcand_r : '0;
  assign last   = (cnt_r == $clog2(fpsc_pkg::MUL_STEPS)'(fpsc_pkg::MUL_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add, sign bit of the multiplier weighs negative
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= {{(fpsc_pkg::PROD_W-fpsc_pkg::INTEG_W){a[fpsc_pkg::INTEG_W-1]}}, a};
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= last ? acc_r - addend : acc_r + addend;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = signed'(acc_r);

endmodule

// ===== rtl/fpsc_div.sv =====
module fpsc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [fpsc_pkg::PROD_W-1:0]   dividend,
  input  logic [fpsc_pkg::DIVR_W-1:0]          divisor,
  output logic                                 done,
  output logic signed [fpsc_pkg::PROD_W-1:0]   quotient
);

  logic                                   busy_r;
  logic                                   done_r;
  logic [$clog2(fpsc_pkg::DIV_STEPS)-1:0] cnt_r;
  logic                                   neg_r;
  logic [fpsc_pkg::PROD_W-1:0]            mag_r;
  logic [fpsc_pkg::DIVR_W-1:0]            rem_r;
  logic [fpsc_pkg::DIVR_W:0]              trial;
  logic                                   qbit;
  logic [fpsc_pkg::DIVR_W:0]              diff;

  assign trial = {rem_r, mag_r[fpsc_pkg::PROD_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(fpsc_pkg::DIV_STEPS)'(fpsc_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division on the magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[fpsc_pkg::PROD_W-1];
      mag_r <= dividend[fpsc_pkg::PROD_W-1] ? -dividend : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[fpsc_pkg::DIVR_W-1:0] : trial[fpsc_pkg::DIVR_W-1:0];
      mag_r <= {mag_r[fpsc_pkg::PROD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(mag_r) : signed'(mag_r);

endmodule

// ===== rtl/fan_pid_speed_control_core.sv =====
// When the sample is at or below the low threshold the core goes straight to the
// result state; otherwise the result is set by four 16-step bit-serial multiplies
// and three 64-step bit-serial divides run one after another, then the result state.
// A new sample is accepted only in the idle state, reached once the last result is
// loaded into a free output register; a new sample is taken while that result waits.
// Reset (synchronous, rst_n low): registers to defaults, integral and prior error cleared.
module fan_pid_speed_control_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fpsc_pkg::TEMP_W-1:0]      in_temperature_mc,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [fpsc_pkg::SPEED_W-1:0]            out_speed_rpm,
  output logic                                    out_regulating,
  input  logic                                    cfg_we,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fpsc_pkg::CFG_W-1:0]              cfg_wdata
);

  logic [15:0]                        min_speed_r;
  logic [7:0]                         low_temp_r;
  logic [7:0]                         target_r;
  logic [7:0]                         interval_r;
  logic signed [fpsc_pkg::GAIN_W-1:0] kp_r;
  logic signed [fpsc_pkg::GAIN_W-1:0] ki_r;
  logic signed [fpsc_pkg::GAIN_W-1:0] kd_r;

  fpsc_pkg::state_t                    state_r;
  fpsc_pkg::state_t                    state_nxt;
  fpsc_pkg::op_t                       op_r;
  logic                                mul_start_r;
  logic                                div_start_r;
  logic signed [fpsc_pkg::ERR_W-1:0]   err_r;
  logic signed [fpsc_pkg::ERR_W-1:0]   prior_r;
  logic signed [fpsc_pkg::INTEG_W-1:0] integ_r;
  logic signed [fpsc_pkg::SUM_W-1:0]   sum_r;
  logic                                reg_r;
  logic                                out_valid_r;
  logic [fpsc_pkg::SPEED_W-1:0]        out_speed_r;
  logic                                out_reg_r;

  logic                                in_acc;
  logic                                out_free;
  logic signed [fpsc_pkg::ERR_W-1:0]   temp_ext;
  logic signed [fpsc_pkg::ERR_W-1:0]   thr;
  logic signed [fpsc_pkg::ERR_W-1:0]   err;
  logic                                regulating;
  logic signed [fpsc_pkg::DIFF_W-1:0]  diff;
  logic signed [fpsc_pkg::INTEG_W-1:0] mul_a;
  logic signed [fpsc_pkg::GAIN_W-1:0]  mul_b;
  logic                                mul_done;
  logic signed [fpsc_pkg::PROD_W-1:0]  mul_prod;
  logic [fpsc_pkg::DIVR_W-1:0]         divisor;
  logic                                div_done;
  logic signed [fpsc_pkg::PROD_W-1:0]  div_quot;
  logic signed [fpsc_pkg::INTEG_W:0]   integ_sum;
  logic signed [fpsc_pkg::INTEG_W-1:0] integ_sat;
  logic signed [fpsc_pkg::SUM_W-1:0]   min_ext;
  logic [fpsc_pkg::SPEED_W-1:0]        speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= 16'd2000;
      low_temp_r  <= 8'd63;
      target_r    <= 8'd66;
      interval_r  <= 8'd7;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fpsc_pkg::CFG_MIN_SPEED: min_speed_r <= cfg_wdata;
        fpsc_pkg::CFG_LOW_TEMP:  low_temp_r  <= cfg_wdata[7:0];
        fpsc_pkg::CFG_TARGET:    target_r    <= cfg_wdata[7:0];
        fpsc_pkg::CFG_INTERVAL:  interval_r  <= cfg_wdata[7:0];
        fpsc_pkg::CFG_KP:        kp_r        <= signed'(cfg_wdata);
        fpsc_pkg::CFG_KI:        ki_r        <= signed'(cfg_wdata);
        fpsc_pkg::CFG_KD:        kd_r        <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != fpsc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign temp_ext   = {in_temperature_mc[fpsc_pkg::TEMP_W-1], in_temperature_mc};
  assign thr        = signed'({2'b00, fpsc_pkg::times1000(low_temp_r)});
  assign err        = temp_ext - signed'({2'b00, fpsc_pkg::times1000(target_r)});
  assign regulating = (temp_ext > thr);
  assign diff       = {err_r[fpsc_pkg::ERR_W-1], err_r} - {prior_r[fpsc_pkg::ERR_W-1], prior_r};

  always_comb begin
    case (op_r)
      fpsc_pkg::OP_INT: begin
        mul_a = {{(fpsc_pkg::INTEG_W-fpsc_pkg::ERR_W){err_r[fpsc_pkg::ERR_W-1]}}, err_r};
        mul_b = signed'({8'd0, interval_r});
      end
      fpsc_pkg::OP_P: begin
        mul_a = {{(fpsc_pkg::INTEG_W-fpsc_pkg::ERR_W){err_r[fpsc_pkg::ERR_W-1]}}, err_r};
        mul_b = kp_r;
      end
      fpsc_pkg::OP_I: begin
        mul_a = integ_r;
        mul_b = ki_r;
      end
      fpsc_pkg::OP_D: begin
        mul_a = {{(fpsc_pkg::INTEG_W-fpsc_pkg::DIFF_W){diff[fpsc_pkg::DIFF_W-1]}}, diff};
        mul_b = kd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // derivative divisor is 1000 * interval, zero interval counts as one
  assign divisor = (op_r != fpsc_pkg::OP_D) ? fpsc_pkg::DIV_1000 :
                   (interval_r == 8'd0)     ? fpsc_pkg::DIV_1000 :
                                              fpsc_pkg::times1000(interval_r);

  assign integ_sum = {integ_r[fpsc_pkg::INTEG_W-1], integ_r} + mul_prod[fpsc_pkg::INTEG_W:0];

  always_comb begin
    if (integ_sum[fpsc_pkg::INTEG_W] != integ_sum[fpsc_pkg::INTEG_W-1]) begin
      integ_sat = integ_sum[fpsc_pkg::INTEG_W] ?
                  signed'({1'b1, {(fpsc_pkg::INTEG_W-1){1'b0}}}) :
                  signed'({1'b0, {(fpsc_pkg::INTEG_W-1){1'b1}}});
    end else begin
      integ_sat = integ_sum[fpsc_pkg::INTEG_W-1:0];
    end
  end

  assign min_ext = signed'({{(fpsc_pkg::SUM_W-16){1'b0}}, min_speed_r});

  always_comb begin
    if (sum_r < min_ext) begin
      speed = min_speed_r;
    end else if (sum_r > signed'({{(fpsc_pkg::SUM_W-fpsc_pkg::SPEED_W){1'b0}},
                                  fpsc_pkg::SPEED_MAX})) begin
      speed = fpsc_pkg::SPEED_MAX;
    end else begin
      speed = sum_r[fpsc_pkg::SPEED_W-1:0];
    end
  end

  fpsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  fpsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (mul_prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = regulating ? fpsc_pkg::ST_MUL : fpsc_pkg::ST_RESULT;
        end
      end
      fpsc_pkg::ST_MUL: begin
        if (mul_done && op_r != fpsc_pkg::OP_INT) begin
          state_nxt = fpsc_pkg::ST_DIV;
        end
      end
      fpsc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = (op_r == fpsc_pkg::OP_D) ? fpsc_pkg::ST_RESULT : fpsc_pkg::ST_MUL;
        end
      end
      fpsc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = fpsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpsc_pkg::ST_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      integ_r     <= '0;
      prior_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        fpsc_pkg::ST_IDLE: begin
          if (in_acc) begin
            sum_r <= min_ext;
            reg_r <= regulating;
            if (regulating) begin
              err_r       <= err;
              op_r        <= fpsc_pkg::OP_INT;
              mul_start_r <= 1'b1;
            end else begin
              integ_r <= '0;
              prior_r <= '0;
            end
          end
        end
        fpsc_pkg::ST_MUL: begin
          if (mul_done) begin
            if (op_r == fpsc_pkg::OP_INT) begin
              integ_r     <= integ_sat;
              op_r        <= fpsc_pkg::OP_P;
              mul_start_r <= 1'b1;
            end else begin
              div_start_r <= 1'b1;
            end
          end
        end
        fpsc_pkg::ST_DIV: begin
          if (div_done) begin
            sum_r <= sum_r + div_quot[fpsc_pkg::SUM_W-1:0];
            if (op_r == fpsc_pkg::OP_D) begin
              prior_r <= err_r;
            end else begin
              op_r        <= (op_r == fpsc_pkg::OP_P) ? fpsc_pkg::OP_I : fpsc_pkg::OP_D;
              mul_start_r <= 1'b1;
            end
          end
        end
        fpsc_pkg::ST_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_speed_r <= speed;
            out_reg_r   <= reg_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_speed_rpm  = out_speed_r;
  assign out_regulating = out_reg_r;

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == fpsc_pkg::ST_MUL)
    else $error("multiply finished outside multiply phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == fpsc_pkg::ST_DIV)
    else $error("divide finished outside divide phase");

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fpsc_pkg::ST_RESULT))
    else $error("transaction presented without a finished result");

endmodule

// ===== tb/sv/fan_pid_speed_control_core_tb.sv =====
module fan_pid_speed_control_core_tb;

  typedef struct packed {
    logic [fpsc_pkg::SPEED_W-1:0] speed;
    logic                         regulating;
  } speed_result_t;

  localparam longint INTEG_MAX = (longint'(1) <<< 47) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< 47);

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [fpsc_pkg::TEMP_W-1:0]  in_temperature_mc = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [fpsc_pkg::SPEED_W-1:0]        out_speed_rpm;
  logic                                out_regulating;
  logic                                cfg_we = 1'b0;
  logic [fpsc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [fpsc_pkg::CFG_W-1:0]          cfg_wdata = '0;

  // shadow copy of the register file
  logic [15:0]               cur_min_speed = 16'd2000;
  logic [7:0]                cur_low_c = 8'd63;
  logic [7:0]                cur_target_c = 8'd66;
  logic [7:0]                cur_interval = 8'd7;
  logic signed [15:0]        cur_kp = '0;
  logic signed [15:0]        cur_ki = '0;
  logic signed [15:0]        cur_kd = '0;

  longint                    prior_err_mc = 0;
  longint                    err_integral = 0;

  logic signed [fpsc_pkg::TEMP_W-1:0] temp_pending_q[$];
  speed_result_t             speed_expected_q[$];
  int                        mismatch_count = 0;

  int                        sender_mode = 0;
  int                        gap_left = 0;
  int                        burst_left = 0;
  int                        stall_mode = 0;
  int                        run_left = 0;
  logic                      run_level = 1'b0;
  bit                        hold_req = 1'b0;
  int                        hold_left = 0;
  speed_result_t             got_res;
  speed_result_t             exp_res;

  fan_pid_speed_control_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_temperature_mc (in_temperature_mc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_rpm     (out_speed_rpm),
    .out_regulating    (out_regulating),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic speed_result_t predict_speed(
      input logic signed [fpsc_pkg::TEMP_W-1:0] sample);
    longint t, lo, tg, iv, minspd, err, acc, ddiv, gp, gi, gd, p, i, d, spd;
    speed_result_t r;
    t = sample;
    lo = cur_low_c;
    tg = cur_target_c;
    iv = cur_interval;
    minspd = cur_min_speed;
    gp = cur_kp;
    gi = cur_ki;
    gd = cur_kd;
    if (t > lo * 1000) begin
      err = t - tg * 1000;
      acc = err_integral + err * iv;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      err_integral = acc;
      ddiv = (iv == 0) ? 1 : iv;
      p = (gp * err) / 1000;
      i = (gi * acc) / 1000;
      d = (gd * (err - prior_err_mc)) / (1000 * ddiv);
      spd = minspd + p + i + d;
      if (spd < minspd) spd = minspd;
      if (spd > 65535) spd = 65535;
      prior_err_mc = err;
      r.speed = spd[fpsc_pkg::SPEED_W-1:0];
      r.regulating = 1'b1;
    end else begin
      err_integral = 0;
      prior_err_mc = 0;
      r.speed = cur_min_speed;
      r.regulating = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR @%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (temp_pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_temperature_mc <= temp_pending_q.pop_front();
        if (sender_mode != 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predictor, on each accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      speed_expected_q.push_back(predict_speed(in_temperature_mc));
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        3: begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 30);
            run_level = ~run_level;
          end else begin
            run_left--;
          end
          out_stall <= run_level;
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res.speed = out_speed_rpm;
      got_res.regulating = out_regulating;
      if (speed_expected_q.size() == 0) begin
        report_mismatch("result transaction with none pending", got_res.speed, 0);
      end else begin
        exp_res = speed_expected_q.pop_front();
        if (got_res.speed !== exp_res.speed)
          report_mismatch("speed_rpm", got_res.speed, exp_res.speed);
        if (got_res.regulating !== exp_res.regulating)
          report_mismatch("regulating", got_res.regulating, exp_res.regulating);
      end
    end
  end

  task automatic write_reg(input logic [fpsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpsc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fpsc_pkg::CFG_MIN_SPEED: cur_min_speed = val;
      fpsc_pkg::CFG_LOW_TEMP:  cur_low_c = val[7:0];
      fpsc_pkg::CFG_TARGET:    cur_target_c = val[7:0];
      fpsc_pkg::CFG_INTERVAL:  cur_interval = val[7:0];
      fpsc_pkg::CFG_KP:        cur_kp = val;
      fpsc_pkg::CFG_KI:        cur_ki = val;
      fpsc_pkg::CFG_KD:        cur_kd = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int min_spd, input int lo, input int tg, input int iv,
                            input int gp, input int gi, input int gd);
    write_reg(fpsc_pkg::CFG_MIN_SPEED, min_spd[15:0]);
    write_reg(fpsc_pkg::CFG_LOW_TEMP, {8'd0, lo[7:0]});
    write_reg(fpsc_pkg::CFG_TARGET, {8'd0, tg[7:0]});
    write_reg(fpsc_pkg::CFG_INTERVAL, {8'd0, iv[7:0]});
    write_reg(fpsc_pkg::CFG_KP, gp[15:0]);
    write_reg(fpsc_pkg::CFG_KI, gi[15:0]);
    write_reg(fpsc_pkg::CFG_KD, gd[15:0]);
  endtask

  // checked on the falling edge so that this edge's updates are settled
  task automatic drain();
    while (temp_pending_q.size() != 0 || in_valid || speed_expected_q.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_temps(input int vals[]);
    foreach (vals[k]) temp_pending_q.push_back(vals[k][fpsc_pkg::TEMP_W-1:0]);
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 35) return int'($urandom_range(0, 100)) - 50;
    if (r < 65) return int'($urandom_range(0, 4000)) - 2000;
    if (r < 80) return int'($urandom_range(0, 65535)) - 32768;
    if (r < 90) return 32767;
    return -32768;
  endfunction

  function automatic int pick_temp();
    int r, base, t;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      base = cur_target_c;
      t = base * 1000 + int'($urandom_range(0, 40000)) - 20000;
    end else if (r < 80) begin
      base = cur_low_c;
      t = base * 1000 + int'($urandom_range(0, 6)) - 3;
    end else if (r < 92) begin
      t = int'($urandom_range(0, 240000)) - 40000;
    end else begin
      t = ($urandom_range(0, 1) == 0) ? -40000 : 200000;
    end
    if (t < -40000) t = -40000;
    if (t > 200000) t = 200000;
    return t;
  endfunction

  task automatic random_phase(input int n_items, input bit hold);
    int min_spd, lo, tg, iv, r;
    r = $urandom_range(0, 9);
    min_spd = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 5) ? int'($urandom_range(0, 65535))
                                                        : int'($urandom_range(0, 5000));
    if ($urandom_range(0, 4) == 0) begin
      lo = $urandom_range(0, 150);
      tg = $urandom_range(0, 150);
    end else begin
      lo = $urandom_range(0, 100);
      tg = lo + int'($urandom_range(0, 50));
    end
    r = $urandom_range(0, 19);
    iv = (r == 0) ? 0 : (r < 3) ? 255 : (r < 6) ? int'($urandom_range(1, 255))
                                                : int'($urandom_range(1, 30));
    set_config(min_spd, lo, tg, iv, pick_gain(), pick_gain(), pick_gain());
    sender_mode = $urandom_range(0, 2);
    stall_mode = $urandom_range(0, 3);
    if (hold) hold_req = 1'b1;
    for (int k = 0; k < n_items; k++)
      temp_pending_q.push_back(fpsc_pkg::TEMP_W'(pick_temp()));
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset defaults, zero gains
    push_temps('{-40000, 200000, 63000, 63001, 66000, 0});
    drain();

    // moderate gains: threshold edge, floor, reset back to minimum
    set_config(1000, 30, 50, 7, 500, 10, 2000);
    sender_mode = 1;
    stall_mode = 1;
    push_temps('{30000, 30001, 50000, 80000, 120000, 45000, 31000, -40000, 200000});
    drain();

    // largest gains, zero floor, longest interval
    set_config(0, 0, 150, 255, 32767, 32767, 32767);
    stall_mode = 3;
    push_temps('{200000, 1, 150000, 100000, 200000});
    drain();

    // zero interval, most negative gains, top minimum speed
    set_config(65535, 150, 0, 0, -32768, -32768, -32768);
    stall_mode = 2;
    push_temps('{150000, 150001, 200000, 170000});
    drain();

    set_config(500, 20, 40, 1, -300, 0, 0);
    sender_mode = 0;
    stall_mode = 0;
    push_temps('{60000, 20000, 10000});
    drain();

    for (int ph = 0; ph < 12; ph++) random_phase(50, ph == 3);

    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && speed_expected_q.size() == 0) begin
      $display("fan_pid_speed_control_core_tb OK");
    end else begin
      $display("fan_pid_speed_control_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("ERROR: timeout");
    $display("fan_pid_speed_control_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fpsc_pkg.sv
rtl/fpsc_mul.sv
rtl/fpsc_div.sv
rtl/fan_pid_speed_control_core.sv
tb/sv/fan_pid_speed_control_core_tb.sv
